@@ hdl/mts_pkg.sv @@
// Package: shared constants and types for the Mandelbrot texture shader.
package mts_pkg;
  localparam int FRAC_BITS_DEF  = 24;
  localparam int ITER_WIDTH_DEF = 16;
  localparam logic [15:0] MAX_ITER_RESET = 16'd255;
  localparam logic [1:0] REG_MAX_ITER = 2'd0;
  localparam logic [1:0] FACE_X = 2'd0;
  localparam logic [1:0] FACE_Z = 2'd1;
  localparam logic [1:0] FACE_OTHER = 2'd2;
  localparam logic [1:0] FACE_SPARE = 2'd3;

  typedef struct packed {
    logic [11:0] red;
    logic [11:0] green;
    logic [11:0] blue;
  } rgb_t;
endpackage

@@ hdl/mts_if.sv @@
// Valid/ready channel interfaces for hit words and color words.
interface mts_in_if;
  logic        valid;
  logic        ready;
  logic signed [31:0] hit_x;
  logic signed [31:0] hit_y;
  logic signed [31:0] hit_z;
  logic [1:0]  face_axis;
  logic [15:0] light_factor;
  modport source (output valid, hit_x, hit_y, hit_z, face_axis, light_factor, input ready);
  modport sink (input valid, hit_x, hit_y, hit_z, face_axis, light_factor, output ready);
endinterface

interface mts_out_if;
  logic        valid;
  logic        ready;
  logic [11:0] red;
  logic [11:0] green;
  logic [11:0] blue;
  modport source (output valid, red, green, blue, input ready);
  modport sink (input valid, red, green, blue, output ready);
endinterface

@@ hdl/mts_mul.sv @@
// Registered signed fixed-point multiplier, product truncated toward zero.
module mts_mul #(
  parameter int W = 32,
  parameter int FB = 24
) (
  input  logic                clk,
  input  logic signed [W-1:0] a,
  input  logic signed [W-1:0] b,
  output logic signed [W-1:0] p
);
  // Operands stay within +-16, so their magnitudes fit in FB + 5 bits.
  localparam int MW = FB + 5;
  logic [MW-1:0] ma, mb;
  logic [2*MW-1:0] prod;
  logic [W-1:0] sh;
  logic neg;
  assign ma = MW'(a[W-1] ? -a : a);
  assign mb = MW'(b[W-1] ? -b : b);
  assign neg = a[W-1] ^ b[W-1];
  assign prod = ma * mb;
  assign sh = W'(prod >> FB);
  always_ff @(posedge clk) begin
    p <= neg ? -$signed(sh) : $signed(sh);
  end
endmodule

@@ hdl/mandelbrot_texture_shader_core.sv @@
// Mandelbrot escape-time texture shader core with one shared multiplier.
// From acceptance to the result word the core runs one or two passes. Each pass maps two
// coordinates, each through the remainder loop, and then runs escape tests through the states
// S_SQX, S_SQY, S_XY and S_UPD; then come the divider and the lighting of the three channels.
// Throughput: one word at a time; ready is high only when idle, in the cycle after a result leaves.
// Reset: synchronous active low; max_iterations returns to 255, control goes idle.
module mandelbrot_texture_shader_core #(
  parameter int FRAC_BITS  = mts_pkg::FRAC_BITS_DEF,
  parameter int ITER_WIDTH = mts_pkg::ITER_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  mts_in_if.sink      in_ch,
  mts_out_if.source   out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [1:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  localparam int W = FRAC_BITS + 17;
  localparam logic signed [W-1:0] ONE = W'(64'sd1 <<< FRAC_BITS);
  localparam logic signed [W-1:0] C24 = W'(((64'sd1 <<< FRAC_BITS) * 24 + 5) / 10);
  localparam logic signed [W-1:0] C15 = W'(((64'sd1 <<< FRAC_BITS) * 3) / 2);
  localparam logic signed [W-1:0] C07 = W'(((64'sd1 <<< FRAC_BITS) * 7 + 5) / 10);
  localparam logic signed [W-1:0] C04 = W'(((64'sd1 <<< FRAC_BITS) * 4 + 5) / 10);
  localparam logic signed [W-1:0] ESC = W'((64'sd1 <<< FRAC_BITS) * 100);
  localparam logic signed [W-1:0] CLMP = W'((64'sd1 <<< FRAC_BITS) * 16);
  localparam logic [ITER_WIDTH-1:0] CAP = '1;
  localparam int DW = ITER_WIDTH + 10;

  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001, S_MAP  = 10'b0000000010, S_REM  = 10'b0000000100,
    S_SQX  = 10'b0000001000, S_SQY  = 10'b0000010000, S_XY   = 10'b0000100000,
    S_UPD  = 10'b0001000000, S_DIV  = 10'b0010000000, S_LITE = 10'b0100000000,
    S_OUT  = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;
  logic [15:0] max_iter_r;
  logic signed [W-1:0] ax_r, ay_r, az_r;
  logic [1:0] face_r;
  logic [15:0] light_r;
  logic [ITER_WIDTH-1:0] lim_r, n_r;
  logic pass_r, axis_r;
  logic signed [W-1:0] rem_r, cx_r, cy_r, x_r, y_r, xx_r, yy_r;
  logic [DW-1:0] quo_r, num_r, rmd_r;
  logic [5:0] cnt_r;
  logic [1:0] ch_r;
  logic [9:0] rr_v, gg_v, bb_v;
  mts_pkg::rgb_t col_r;
  logic signed [W-1:0] ma, mb, mp;

  mts_mul #(.W(W), .FB(FRAC_BITS)) u_mul (.clk(clk), .a(ma), .b(mb), .p(mp));

  function automatic logic signed [W-1:0] absq(input logic signed [31:0] v);
    logic signed [W-1:0] e;
    e = W'(v);
    if (e < 0) e = -e;
    return e <<< (FRAC_BITS - 16);
  endfunction

  function automatic logic signed [W-1:0] clampv(input logic signed [W-1:0] v);
    if (v > CLMP) return CLMP;
    if (v < -CLMP) return -CLMP;
    return v;
  endfunction

  // Pre-offset and post-offset for the coordinate being mapped.
  logic signed [W-1:0] pre_v, post_v, mag_v;
  logic fx;
  always_comb begin
    fx = (face_r == mts_pkg::FACE_X) || (face_r == mts_pkg::FACE_Z);
    if (!axis_r) mag_v = fx ? (face_r == mts_pkg::FACE_X ? az_r : ax_r) : ax_r;
    else mag_v = fx ? ay_r : az_r;
    // Tags: a = first-kind axis (pre 0/1, post 1.5/0.4), b = other (pre 1.5/2, post 1/0.7).
    if ((fx && !axis_r) || (!fx && axis_r)) begin
      pre_v  = pass_r ? ONE : '0;
      post_v = pass_r ? C04 : C15;
    end else begin
      pre_v  = pass_r ? (ONE <<< 1) : C15;
      post_v = pass_r ? C07 : ONE;
    end
  end

  // Remainder by subtracting 2.4 repeatedly; the magnitude is at most 2^15 so
  // subtract in shifted multiples for a bounded step count.
  logic signed [W-1:0] rem_abs, scaled, mapped;
  always_comb begin
    rem_abs = rem_r[W-1] ? -rem_r : rem_r;
    scaled = pass_r ? W'((rem_r * 3) / 2) : rem_r;
    mapped = scaled - post_v;
  end

  logic signed [W:0] sum2;
  logic signed [W-1:0] xt, yt;
  assign sum2 = {xx_r[W-1], xx_r} + {yy_r[W-1], yy_r};
  assign xt = xx_r - yy_r + cx_r;
  assign yt = (mp <<< 1) + cy_r;

  always_comb begin
    ma = x_r;
    mb = x_r;
    unique case (state_r)
      S_SQY: begin ma = y_r; mb = y_r; end
      S_XY:  begin ma = x_r; mb = y_r; end
      default: begin ma = x_r; mb = x_r; end
    endcase
  end

  logic done_iter;
  assign done_iter = (n_r == lim_r) || (sum2 > {ESC[W-1], ESC});

  logic [DW:0] trial;
  assign trial = {rmd_r[DW-2:0], num_r[DW-1]} - {1'b0, DW'(lim_r)};

  logic [9:0] k, chv;
  logic [25:0] lprod;
  always_comb begin
    k = 10'(767 - quo_r);
    if (k < 10'd256) begin rr_v = 10'(255 - k); gg_v = 10'd255; bb_v = 10'd255; end
    else if (k < 10'd512) begin rr_v = '0; gg_v = 10'(512 - k); bb_v = 10'd255; end
    else begin rr_v = '0; gg_v = '0; bb_v = 10'(768 - k); end
    if (n_r == lim_r) begin rr_v = '0; gg_v = '0; bb_v = '0; end
    case (ch_r)
      2'd0: chv = rr_v;
      2'd1: chv = gg_v;
      default: chv = bb_v;
    endcase
    lprod = chv * light_r;
  end

  logic [11:0] sat;
  assign sat = (lprod[25:12] > 14'd4095) ? 12'hfff : lprod[23:12];

  assign in_ch.ready = (state_r == S_IDLE);
  assign out_ch.valid = (state_r == S_OUT);
  assign out_ch.red = col_r.red;
  assign out_ch.green = col_r.green;
  assign out_ch.blue = col_r.blue;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == mts_pkg::REG_MAX_ITER) ? {16'd0, max_iter_r} : 32'd0;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_ch.valid) state_nxt = S_MAP;
      S_MAP:  state_nxt = S_REM;
      S_REM:  if (rem_abs < C24) state_nxt = axis_r ? S_SQX : S_MAP;
      S_SQX:  state_nxt = S_SQY;
      S_SQY:  state_nxt = S_XY;
      S_XY:   state_nxt = S_UPD;
      S_UPD:  if (done_iter) state_nxt = (n_r == lim_r && !pass_r) ? S_MAP : S_DIV;
              else state_nxt = S_SQX;
      S_DIV:  if (cnt_r == 6'(DW)) state_nxt = S_LITE;
      S_LITE: if (ch_r == 2'd2) state_nxt = S_OUT;
      S_OUT:  if (out_ch.ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      max_iter_r <= mts_pkg::MAX_ITER_RESET;
    end else begin
      state_r <= state_nxt;
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == mts_pkg::REG_MAX_ITER)
        max_iter_r <= cfg_pwdata[15:0];
    end
  end

  // Step of the remainder: subtract the largest 2.4 * 2^j not above |r|.
  logic signed [W-1:0] step_v;
  always_comb begin
    step_v = C24;
    for (int j = 1; j < 16; j++)
      if ((C24 <<< j) <= rem_abs && (C24 <<< j) > 0) step_v = C24 <<< j;
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        ax_r <= absq(in_ch.hit_x);
        ay_r <= absq(in_ch.hit_y);
        az_r <= absq(in_ch.hit_z);
        face_r <= in_ch.face_axis;
        light_r <= in_ch.light_factor;
        lim_r <= (ITER_WIDTH >= 16 || max_iter_r <= 16'(CAP)) ? ITER_WIDTH'(max_iter_r) : CAP;
        pass_r <= 1'b0;
        axis_r <= 1'b0;
      end
      S_MAP: rem_r <= mag_v - pre_v;
      S_REM: begin
        if (rem_abs >= C24) rem_r <= rem_r[W-1] ? rem_r + step_v : rem_r - step_v;
        else begin
          if (!axis_r) begin cx_r <= mapped; x_r <= mapped; end
          else begin cy_r <= mapped; y_r <= mapped; n_r <= '0; end
          axis_r <= ~axis_r;
        end
      end
      S_SQY: xx_r <= mp;
      S_XY:  yy_r <= mp;
      S_UPD: begin
        if (!done_iter) begin
          x_r <= clampv(xt);
          y_r <= clampv(yt);
          n_r <= n_r + 1'b1;
        end else if (n_r == lim_r && !pass_r) begin
          pass_r <= 1'b1;
        end
        num_r <= DW'(n_r) * DW'(767);
        rmd_r <= '0;
        quo_r <= '0;
        cnt_r <= '0;
        ch_r <= '0;
      end
      S_DIV: if (cnt_r != 6'(DW)) begin
        if (!trial[DW]) begin rmd_r <= trial[DW-1:0]; quo_r <= {quo_r[DW-2:0], 1'b1}; end
        else begin rmd_r <= {rmd_r[DW-2:0], num_r[DW-1]}; quo_r <= {quo_r[DW-2:0], 1'b0}; end
        num_r <= num_r << 1;
        cnt_r <= cnt_r + 1'b1;
      end
      S_LITE: begin
        case (ch_r)
          2'd0: col_r.red <= sat;
          2'd1: col_r.green <= sat;
          default: col_r.blue <= sat;
        endcase
        ch_r <= ch_r + 1'b1;
      end
      default: ;
    endcase
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(col_r))
    else $error("result word changed while stalled");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("accepted word while busy");
  a_iter: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_UPD |-> n_r <= lim_r)
    else $error("iteration count beyond limit");
endmodule

@@ tb/testbench.sv @@
// Testbench for the Mandelbrot texture shader core: directed table, random words, scoreboard.
module testbench;
  localparam longint FX_ONE = longint'(1) << 24;
  localparam longint FX_2_4 = (FX_ONE * 24 + 5) / 10;
  localparam longint FX_1_5 = (FX_ONE * 3) / 2;
  localparam longint FX_0_7 = (FX_ONE * 7 + 5) / 10;
  localparam longint FX_0_4 = (FX_ONE * 4 + 5) / 10;
  localparam longint FX_ESC = FX_ONE * 100;
  localparam longint FX_CLAMP = FX_ONE * 16;
  localparam int CYCLE_LIMIT = 4000000;
  localparam int DIR_ROWS = 13;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic [1:0]         face;
    logic [15:0]        light;
  } hit_t;

  typedef struct packed {
    hit_t hit;
    bit   known;
    mts_pkg::rgb_t rgb;
  } dir_row_t;

  logic clk;
  logic rst_n;
  logic cfg_psel, cfg_penable, cfg_pwrite;
  logic [1:0] cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  mts_in_if in_ch();
  mts_out_if out_ch();

  mandelbrot_texture_shader_core dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  mts_pkg::rgb_t color_queue[$];
  int unsigned iter_limit;
  int errors;
  int words_sent;
  int colors_seen;
  int black_seen;
  int sender_idle_pct;
  int receiver_stall_pct;
  bit hold_request;
  int cycles;
  dir_row_t dir_rows [0:DIR_ROWS-1];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Signed fixed-point product, truncated toward zero.
  function automatic longint fx_mul(longint a, longint b);
    longint unsigned ma, mb, p;
    bit neg;
    neg = (a < 0) != (b < 0);
    ma = (a < 0) ? -a : a;
    mb = (b < 0) ? -b : b;
    p = (ma * mb) >> 24;
    return neg ? -longint'(p) : longint'(p);
  endfunction

  function automatic longint fx_clamp(longint v);
    if (v > FX_CLAMP) return FX_CLAMP;
    if (v < -FX_CLAMP) return -FX_CLAMP;
    return v;
  endfunction

  function automatic longint coord_mag(logic signed [31:0] raw);
    longint v;
    v = longint'($signed(raw));
    if (v < 0) v = -v;
    return v << 8;
  endfunction

  function automatic longint tile_coord(longint mag, longint pre, bit scaled, longint post);
    longint r;
    r = (mag - pre) % FX_2_4;
    if (scaled) r = (r * 3) / 2;
    return r - post;
  endfunction

  function automatic int unsigned escape_steps(longint cx, longint cy, int unsigned lim);
    longint x, y, xx, yy, xt, yt;
    int unsigned n;
    x = cx;
    y = cy;
    n = 0;
    while (n < lim) begin
      xx = fx_mul(x, x);
      yy = fx_mul(y, y);
      if (xx + yy > FX_ESC) break;
      xt = xx - yy + cx;
      yt = fx_mul(x, y) * 2 + cy;
      x = fx_clamp(xt);
      y = fx_clamp(yt);
      n++;
    end
    return n;
  endfunction

  function automatic logic [11:0] lit_channel(int unsigned ch, logic [15:0] light);
    longint unsigned v;
    v = (longint'(ch) * light) >> 12;
    return (v > 4095) ? 12'd4095 : v[11:0];
  endfunction

  function automatic mts_pkg::rgb_t shade_hit(hit_t h, int unsigned lim);
    longint ax, ay, az, cx, cy, u;
    int unsigned n, k, r, g, b;
    bit xz_face;
    mts_pkg::rgb_t c;
    ax = coord_mag(h.x);
    ay = coord_mag(h.y);
    az = coord_mag(h.z);
    xz_face = (h.face == mts_pkg::FACE_X) || (h.face == mts_pkg::FACE_Z);
    u = (h.face == mts_pkg::FACE_X) ? az : ax;
    if (lim > 65535) lim = 65535;
    if (xz_face) begin
      cx = tile_coord(u, 0, 0, FX_1_5);
      cy = tile_coord(ay, FX_1_5, 0, FX_ONE);
    end else begin
      cx = tile_coord(ax, FX_1_5, 0, FX_ONE);
      cy = tile_coord(az, 0, 0, FX_1_5);
    end
    n = escape_steps(cx, cy, lim);
    if (n == lim) begin
      // The first tile stayed bounded; retry with the scaled mapping.
      if (xz_face) begin
        cx = tile_coord(u, FX_ONE, 1, FX_0_4);
        cy = tile_coord(ay, 2 * FX_ONE, 1, FX_0_7);
      end else begin
        cx = tile_coord(ax, 2 * FX_ONE, 1, FX_0_7);
        cy = tile_coord(az, FX_ONE, 1, FX_0_4);
      end
      n = escape_steps(cx, cy, lim);
    end
    if (n == lim) begin
      r = 0; g = 0; b = 0;
    end else begin
      k = 767 - int'((longint'(n) * 767) / lim);
      if (k < 256) begin
        r = 255 - k; g = 255; b = 255;
      end else if (k < 512) begin
        r = 0; g = 512 - k; b = 255;
      end else begin
        r = 0; g = 0; b = 768 - k;
      end
    end
    c.red = lit_channel(r, h.light);
    c.green = lit_channel(g, h.light);
    c.blue = lit_channel(b, h.light);
    return c;
  endfunction

  // Color receiver: checks each word against the oldest expectation.
  initial begin
    int hold_left;
    bit hold_done;
    mts_pkg::rgb_t want;
    hold_left = 0;
    hold_done = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_ch.valid && out_ch.ready) begin
        colors_seen++;
        if (color_queue.size() == 0) begin
          $display("%0t: unexpected color word %h", $time,
                   {out_ch.red, out_ch.green, out_ch.blue});
          errors++;
        end else begin
          want = color_queue.pop_front();
          if (want == 36'd0) black_seen++;
          if (out_ch.red !== want.red || out_ch.green !== want.green ||
              out_ch.blue !== want.blue) begin
            $display("%0t: color mismatch expected r=%0d g=%0d b=%0d actual r=%0d g=%0d b=%0d",
                     $time, want.red, want.green, want.blue,
                     out_ch.red, out_ch.green, out_ch.blue);
            errors++;
          end
        end
      end
      if (hold_request && !hold_done) begin
        hold_done = 1'b1;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
      end
    end
  end

  task automatic cfg_write(logic [1:0] idx, logic [31:0] value);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= 2'(4 * idx);
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    if (idx == mts_pkg::REG_MAX_ITER) iter_limit = value[15:0];
  endtask

  task automatic cfg_check(logic [1:0] idx, logic [31:0] want);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_paddr <= 2'(4 * idx);
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata[15:0] !== want[15:0]) begin
      $display("%0t: register read expected %0d actual %0d", $time, want[15:0],
               cfg_prdata[15:0]);
      errors++;
    end
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic offer_hit(hit_t h, bit known, mts_pkg::rgb_t typed);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.hit_x <= h.x;
    in_ch.hit_y <= h.y;
    in_ch.hit_z <= h.z;
    in_ch.face_axis <= h.face;
    in_ch.light_factor <= h.light;
    do @(posedge clk); while (!in_ch.ready);
    color_queue.push_back(known ? typed : shade_hit(h, iter_limit));
    words_sent++;
  endtask

  task automatic drain_colors();
    in_ch.valid <= 1'b0;
    while (color_queue.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_coord();
    logic [31:0] v;
    if ($urandom_range(0, 3) == 0) return $urandom();
    // Mostly a few tiles around the origin, where the fractal has detail.
    v = $urandom_range(0, 32'h60000);
    return $urandom_range(0, 1) ? -v : v;
  endfunction

  function automatic hit_t rand_hit();
    hit_t h;
    h.x = rand_coord();
    h.y = rand_coord();
    h.z = rand_coord();
    h.face = 2'($urandom_range(0, 3));
    case ($urandom_range(0, 5))
      0: h.light = 16'hFFFF;
      1: h.light = 16'h1000;
      default: h.light = 16'($urandom());
    endcase
    return h;
  endfunction

  task automatic random_phase(int unsigned lim, int idle, int stall, int count);
    drain_colors();
    cfg_write(mts_pkg::REG_MAX_ITER, lim);
    sender_idle_pct = idle;
    receiver_stall_pct = stall;
    for (int i = 0; i < count; i++) offer_hit(rand_hit(), 1'b0, '0);
  endtask

  initial begin
    hit_t quick;
    rst_n <= 1'b0;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    cfg_paddr <= '0;
    cfg_pwdata <= '0;
    in_ch.valid <= 1'b0;
    in_ch.hit_x <= '0;
    in_ch.hit_y <= '0;
    in_ch.hit_z <= '0;
    in_ch.face_axis <= '0;
    in_ch.light_factor <= '0;
    errors = 0;
    words_sent = 0;
    hold_request = 1'b0;
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    iter_limit = mts_pkg::MAX_ITER_RESET;

    // Point (0.8, 1.3) in the first tile escapes after two steps.
    quick = '{x: 32'h0, y: 32'h3CCCC, z: 32'h24CCC, face: mts_pkg::FACE_X, light: 16'h1000};
    dir_rows = '{
      '{hit: '{32'h28000, 32'h0, 32'h18000, mts_pkg::FACE_OTHER, 16'h1000}, known: 0, rgb: '0},
      '{hit: '{32'h28000, 32'h0, 32'h18000, mts_pkg::FACE_OTHER, 16'h0}, known: 1, rgb: '0},
      '{hit: quick, known: 0, rgb: '0},
      '{hit: '{32'h24CCC, 32'h3CCCC, 32'h0, mts_pkg::FACE_Z, 16'h1000}, known: 0, rgb: '0},
      '{hit: '{32'hFFFDB334, 32'h3CCCC, 32'h28000, mts_pkg::FACE_SPARE, 16'h1000},
        known: 0, rgb: '0},
      '{hit: '{32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, mts_pkg::FACE_X, 16'hFFFF},
        known: 0, rgb: '0},
      '{hit: '{32'h80000000, 32'h80000000, 32'h80000000, mts_pkg::FACE_Z, 16'hFFFF},
        known: 0, rgb: '0},
      '{hit: '{32'h80000000, 32'h7FFFFFFF, 32'h80000000, mts_pkg::FACE_OTHER, 16'h0001},
        known: 0, rgb: '0},
      '{hit: '{32'h0, 32'h0, 32'h0, mts_pkg::FACE_X, 16'hFFFF}, known: 0, rgb: '0},
      '{hit: '{32'h0, 32'h0, 32'h0, mts_pkg::FACE_SPARE, 16'h0}, known: 1, rgb: '0},
      '{hit: '{32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, mts_pkg::FACE_OTHER, 16'h8000},
        known: 0, rgb: '0},
      '{hit: '{32'h0, 32'h3CCCC, 32'h24CCC, mts_pkg::FACE_X, 16'hFFFF}, known: 0, rgb: '0},
      '{hit: '{32'h7FFFFFFF, 32'h0, 32'h7FFFFFFF, mts_pkg::FACE_SPARE, 16'h0},
        known: 1, rgb: '0}
    };

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    cfg_check(mts_pkg::REG_MAX_ITER, mts_pkg::MAX_ITER_RESET);

    for (int i = 0; i < DIR_ROWS; i++)
      offer_hit(dir_rows[i].hit, dir_rows[i].known, dir_rows[i].rgb);

    random_phase(1, 0, 0, 60);
    random_phase(16, 78, 0, 70);
    random_phase(40, 0, 78, 70);
    random_phase(8, 20, 20, 70);
    // A zero limit runs no iteration at all, so every word comes back black.
    random_phase(0, 20, 20, 15);

    drain_colors();
    cfg_write(mts_pkg::REG_MAX_ITER, 65535);
    sender_idle_pct = 0;
    receiver_stall_pct = 20;
    for (int i = 0; i < 3; i++) begin
      quick.light = 16'($urandom());
      offer_hit(quick, 1'b0, '0);
    end

    // Hold the color side off so the core backs up and stalls hit words.
    drain_colors();
    cfg_write(mts_pkg::REG_MAX_ITER, 24);
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    hold_request = 1'b1;
    for (int i = 0; i < 40; i++) offer_hit(rand_hit(), 1'b0, '0);
    // Let the pipeline run dry before carrying on.
    in_ch.valid <= 1'b0;
    while (color_queue.size() != 0) @(posedge clk);
    sender_idle_pct = 50;
    receiver_stall_pct = 50;
    for (int i = 0; i < 40; i++) offer_hit(rand_hit(), 1'b0, '0);

    drain_colors();
    repeat (200) @(posedge clk);
    $display("Sent %0d hit words over limits 0, 1, 8, 16, 24, 40, 255 and 65535;",
             words_sent);
    $display("received %0d color words, %0d of them black.", colors_seen, black_seen);
    if (errors == 0 && color_queue.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
